// ----- rtl/plc_pkg.sv -----
// Shared widths and prefix codes for the length prefix codec.
// Used by prefix_length_codec; depends on nothing.
package plc_pkg;

	localparam int LEN_W  = 29;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 2;

	// largest length that fits in one, two and three bytes
	localparam logic [LEN_W-1:0] MAX_LEN1 = 29'h0000007f;
	localparam logic [LEN_W-1:0] MAX_LEN2 = 29'h00003fff;
	localparam logic [LEN_W-1:0] MAX_LEN3 = 29'h001fffff;

	// prefix of the first byte, by byte count
	localparam logic [BYTE_W-1:0] PFX_TWO   = 8'h80;
	localparam logic [BYTE_W-1:0] PFX_THREE = 8'hc0;
	localparam logic [BYTE_W-1:0] PFX_FOUR  = 8'he0;

	localparam logic [BYTE_W-1:0] MASK_SIX  = 8'h3f;
	localparam logic [BYTE_W-1:0] MASK_FIVE = 8'h1f;

	// byte count minus one
	localparam logic [CNT_W-1:0] CNT_ONE   = 2'd0;
	localparam logic [CNT_W-1:0] CNT_TWO   = 2'd1;
	localparam logic [CNT_W-1:0] CNT_THREE = 2'd2;
	localparam logic [CNT_W-1:0] CNT_FOUR  = 2'd3;

endpackage

// ----- rtl/prefix_length_codec.sv -----
// Length prefix codec: encodes 29-bit lengths into one to four bytes, or
// decodes a byte stream back into lengths. Depends on plc_pkg.
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------------
// in      | in        | in_valid/in_ready  | length_in, byte_in, byte_present
// out     | out       | out_valid/out_ready| byte_out, last_byte, length_out,
//         |           |                    | length_done, format_error
// cfg     | in        | cfg_wr_en          | cfg_wr_data (encode_mode)
//
// One input register and one result register. A decode item leaves the input
// register when it fires; an encode item stays there while it gives its bytes,
// one to four, set by the byte serialiser in the input register.
// A word is taken every cycle while results drain, in encode mode only as the
// last byte moves on; a stalled result holds the result and input registers.
// Reset clears the mode, decode state and sticky error; no clearing pass.
module prefix_length_codec (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [plc_pkg::LEN_W-1:0]   length_in,
	input  logic [plc_pkg::BYTE_W-1:0]  byte_in,
	input  logic                        byte_present,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [plc_pkg::BYTE_W-1:0]  byte_out,
	output logic                        last_byte,
	output logic [plc_pkg::LEN_W-1:0]   length_out,
	output logic                        length_done,
	output logic                        format_error
);
	import plc_pkg::*;

	logic                encode_mode_q;

	// input register
	logic                valid_s1;
	logic                enc_s1;
	logic [LEN_W-1:0]    len_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                present_s1;
	logic [CNT_W-1:0]    cnt_s1;
	logic [CNT_W-1:0]    idx_q;

	// decode state
	logic [CNT_W-1:0]    left_q;
	logic [LEN_W-1:0]    partial_q;
	logic                failed_q;

	// result register
	logic                out_valid_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                last_q;
	logic [LEN_W-1:0]    len_out_q;
	logic                done_q;
	logic                err_q;

	logic                slot_free;
	logic                fire;
	logic                enc_last;
	logic                s1_done;
	logic [CNT_W-1:0]    cnt_in;
	logic [CNT_W-1:0]    shift;
	logic [BYTE_W-1:0]   enc_byte;

	logic                dec_res;
	logic [LEN_W-1:0]    dec_len;
	logic                dec_err;
	logic [CNT_W-1:0]    left_nxt;
	logic [LEN_W-1:0]    partial_nxt;
	logic                failed_nxt;
	logic [LEN_W-1:0]    joined;

	assign slot_free = !out_valid_q || out_ready;
	assign fire      = valid_s1 && slot_free;
	assign enc_last  = (idx_q == cnt_s1);
	assign s1_done   = fire && (!enc_s1 || enc_last);
	assign in_ready  = !valid_s1 || s1_done;

	always_comb begin
		if (length_in <= MAX_LEN1) begin
			cnt_in = CNT_ONE;
		end else if (length_in <= MAX_LEN2) begin
			cnt_in = CNT_TWO;
		end else if (length_in <= MAX_LEN3) begin
			cnt_in = CNT_THREE;
		end else begin
			cnt_in = CNT_FOUR;
		end
	end

	// pick the byte for the current position, most significant first
	assign shift = cnt_s1 - idx_q;

	always_comb begin
		case (shift)
			2'd0:    enc_byte = len_s1[7:0];
			2'd1:    enc_byte = len_s1[15:8];
			2'd2:    enc_byte = len_s1[23:16];
			default: enc_byte = {3'b000, len_s1[28:24]};
		endcase
		if (idx_q == CNT_ONE) begin
			case (cnt_s1)
				CNT_TWO:   enc_byte = enc_byte | PFX_TWO;
				CNT_THREE: enc_byte = enc_byte | PFX_THREE;
				CNT_FOUR:  enc_byte = enc_byte | PFX_FOUR;
				default:   enc_byte = enc_byte;
			endcase
		end
	end

	assign joined = {partial_q[LEN_W-BYTE_W-1:0], byte_s1};

	always_comb begin
		dec_res     = 1'b0;
		dec_len     = '0;
		dec_err     = 1'b0;
		left_nxt    = left_q;
		partial_nxt = partial_q;
		failed_nxt  = failed_q;
		if (failed_q || !present_s1) begin
			// drop any partial length and stick
			failed_nxt  = 1'b1;
			left_nxt    = '0;
			partial_nxt = '0;
			dec_res     = 1'b1;
			dec_err     = 1'b1;
		end else if (left_q == '0) begin
			if (!byte_s1[7]) begin
				dec_res = 1'b1;
				dec_len = {{(LEN_W-BYTE_W){1'b0}}, byte_s1};
			end else if (!byte_s1[6]) begin
				partial_nxt = {{(LEN_W-BYTE_W){1'b0}}, byte_s1 & MASK_SIX};
				left_nxt    = 2'd1;
			end else if (!byte_s1[5]) begin
				partial_nxt = {{(LEN_W-BYTE_W){1'b0}}, byte_s1 & MASK_FIVE};
				left_nxt    = 2'd2;
			end else begin
				partial_nxt = {{(LEN_W-BYTE_W){1'b0}}, byte_s1 & MASK_FIVE};
				left_nxt    = 2'd3;
			end
		end else begin
			left_nxt = left_q - 2'd1;
			if (left_nxt == '0) begin
				dec_res     = 1'b1;
				dec_len     = joined;
				partial_nxt = '0;
			end else begin
				partial_nxt = joined;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			encode_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
				idx_q    <= '0;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end else if (fire) begin
				// advance to the next encoded byte
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			enc_s1     <= encode_mode_q;
			len_s1     <= length_in;
			byte_s1    <= byte_in;
			present_s1 <= byte_present;
			cnt_s1     <= cnt_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			partial_q <= '0;
			failed_q  <= 1'b0;
		end else if (fire && !enc_s1) begin
			left_q    <= left_nxt;
			partial_q <= partial_nxt;
			failed_q  <= failed_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= valid_s1 && (enc_s1 || dec_res);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (enc_s1) begin
				byte_q    <= enc_byte;
				last_q    <= enc_last;
				len_out_q <= '0;
				done_q    <= 1'b0;
				err_q     <= 1'b0;
			end else begin
				byte_q    <= '0;
				last_q    <= 1'b0;
				len_out_q <= dec_len;
				done_q    <= 1'b1;
				err_q     <= dec_err;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_out     = byte_q;
	assign last_byte    = last_q;
	assign length_out   = len_out_q;
	assign length_done  = done_q;
	assign format_error = err_q;

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but word refused");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("format error cleared without reset");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && enc_s1) |-> (idx_q <= cnt_s1))
		else $error("encode byte index past byte count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (len_out_q == '0 && done_q))
		else $error("format error result carries a length");

	a_enc_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> !done_q)
		else $error("encoded byte flagged as decoded length");

endmodule
